FILE: sv/fpm_pkg.sv
package fpm_pkg;

    // Channel count default and the fixed pin / mask width of the item
    localparam int CHANNELS_DEF = 4;
    localparam int PIN_COUNT    = 4;

    localparam int ELAPSED_W = 24;
    localparam int IDLE_W    = 23;
    localparam int LITER_W   = 24;
    localparam int LIMIT_W   = 22;
    localparam int SEC_W     = 12;

    localparam logic [9:0] MS_PER_SEC = 10'd1000;
    localparam logic signed [LITER_W-1:0] LITER_MAX  = 24'sh7FFFFF;
    localparam logic signed [LITER_W-1:0] LITER_NONE = -24'sd1;

    typedef enum logic [1:0] {
        OP_MS_TICK  = 2'd0,
        OP_START    = 2'd1,
        OP_STOP     = 2'd2,
        OP_SEC_TICK = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]       operation;
        logic [1:0]       channel;
        logic [3:0]       pin_levels;
        logic [SEC_W-1:0] min_seconds;
        logic [SEC_W-1:0] max_seconds;
    } t_fpm_in;

    typedef struct packed {
        logic [1:0]                  report_channel;
        logic [ELAPSED_W-1:0]        elapsed_ms;
        logic signed [LITER_W-1:0]   liters;
        logic                        running;
        logic                        done_res;
        logic                        failed;
        logic [PIN_COUNT-1:0]        done_mask;
        logic [PIN_COUNT-1:0]        error_mask;
    } t_fpm_out;

    // Per-lane status after the current item, plus finish events
    typedef struct packed {
        logic [ELAPSED_W-1:0]      elapsed;
        logic signed [LITER_W-1:0] liters;
        logic                      running;
        logic                      done;
        logic                      failed;
        logic                      ev_done;
        logic                      ev_err;
    } t_lane_stat;

    // Convert seconds to milliseconds (fits 22 bits for a 12-bit input)
    function automatic logic [LIMIT_W-1:0] sec_to_ms(input logic [SEC_W-1:0] secs);
        logic [LIMIT_W-1:0] prod;
        prod = {{(LIMIT_W-SEC_W){1'b0}}, secs} * {{(LIMIT_W-10){1'b0}}, MS_PER_SEC};
        return prod;
    endfunction

endpackage

FILE: sv/fpm_stream_if.sv
interface fpm_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/fpm_lane.sv
module fpm_lane
    import fpm_pkg::*;
#(
    parameter int LANE_IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [1:0]         i_op,
    input  logic [1:0]         i_channel,
    input  logic [PIN_COUNT-1:0] i_pin_levels,
    input  logic [LIMIT_W-1:0] i_min_ms,
    input  logic [LIMIT_W-1:0] i_max_ms,
    output t_lane_stat         o_stat
);

    localparam logic [1:0] PIN_SEL = 2'(LANE_IDX);

    logic [ELAPSED_W-1:0]      r_elapsed, n_elapsed;
    logic [IDLE_W-1:0]         r_idle, n_idle;
    logic signed [LITER_W-1:0] r_liter, n_liter;
    logic [LIMIT_W-1:0]        r_min, n_min;
    logic [LIMIT_W-1:0]        r_max, n_max;
    logic r_prev, n_prev;
    logic r_running, n_running;
    logic r_done, n_done;
    logic r_failed, n_failed;
    logic r_tick, n_tick;
    logic ev_done, ev_err;
    logic act, hit;

    assign act = (LANE_IDX < PIN_COUNT) && !i_pin_levels[PIN_SEL];
    assign hit = (32'(i_channel) == LANE_IDX);

    // Next state for the accepted item
    always_comb begin
        n_elapsed = r_elapsed;
        n_idle    = r_idle;
        n_liter   = r_liter;
        n_min     = r_min;
        n_max     = r_max;
        n_prev    = r_prev;
        n_running = r_running;
        n_done    = r_done;
        n_failed  = r_failed;
        n_tick    = r_tick;
        ev_done   = 1'b0;
        ev_err    = 1'b0;
        if (i_fire) begin
            case (i_op)
                OP_MS_TICK: begin
                    n_tick = 1'b1;
                    if (r_running) begin
                        if (r_idle != '1) n_idle = r_idle + 1'b1;
                        if (!r_liter[LITER_W-1] && r_elapsed != '1)
                            n_elapsed = r_elapsed + 1'b1;
                        if (n_idle > {1'b0, r_max}) begin
                            // idle timeout
                            n_running = 1'b0;
                            n_failed  = 1'b1;
                            n_done    = 1'b0;
                            ev_err    = 1'b1;
                        end else if (!r_prev && act) begin
                            // pulse edge: count and clear idle
                            if (r_liter != LITER_MAX) n_liter = r_liter + 1'b1;
                            n_idle = '0;
                            if (n_elapsed > {2'b00, r_min}) begin
                                n_running = 1'b0;
                                n_done    = 1'b1;
                                n_failed  = 1'b0;
                                ev_done   = 1'b1;
                            end else begin
                                n_prev = act;
                            end
                        end else begin
                            n_prev = act;
                        end
                    end
                end
                OP_START: begin
                    if (hit) begin
                        n_done    = 1'b0;
                        n_failed  = 1'b0;
                        n_elapsed = '0;
                        n_idle    = '0;
                        n_liter   = LITER_NONE;
                        n_prev    = act;
                        n_min     = i_min_ms;
                        n_max     = i_max_ms;
                        n_tick    = 1'b0;
                        n_running = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (hit) begin
                        n_running = 1'b0;
                        n_done    = 1'b1;
                        n_failed  = 1'b0;
                        ev_done   = 1'b1;
                    end
                end
                OP_SEC_TICK: begin
                    // missing millisecond ticks within the last second
                    if (r_running && !r_tick) begin
                        n_running = 1'b0;
                        n_done    = 1'b0;
                        n_failed  = 1'b1;
                        ev_err    = 1'b1;
                    end
                    n_tick = 1'b0;
                end
                default: begin
                    n_tick = r_tick;
                end
            endcase
        end
    end

    // Hold lane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_idle    <= '0;
            r_liter   <= '0;
            r_min     <= '0;
            r_max     <= '0;
            r_prev    <= 1'b0;
            r_running <= 1'b0;
            r_done    <= 1'b0;
            r_failed  <= 1'b0;
            r_tick    <= 1'b0;
        end else begin
            r_elapsed <= n_elapsed;
            r_idle    <= n_idle;
            r_liter   <= n_liter;
            r_min     <= n_min;
            r_max     <= n_max;
            r_prev    <= n_prev;
            r_running <= n_running;
            r_done    <= n_done;
            r_failed  <= n_failed;
            r_tick    <= n_tick;
        end
    end

    assign o_stat = '{
        elapsed: n_elapsed,
        liters:  n_liter,
        running: n_running,
        done:    n_done,
        failed:  n_failed,
        ev_done: ev_done,
        ev_err:  ev_err
    };

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_done && r_failed) && !(r_running && (r_done || r_failed)))
        else $error("lane status flags overlap");

    a_liter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_liter[LITER_W-1] || r_liter == LITER_NONE)
        else $error("liter count below -1");

    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_op == OP_START && hit) |=> (r_running && r_liter == LITER_NONE
            && r_idle == '0 && r_elapsed == '0))
        else $error("start did not arm lane");

    a_no_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_op == OP_MS_TICK || i_op == OP_SEC_TICK) && !r_running)
            |-> !(ev_done || ev_err))
        else $error("idle lane finished on a tick");

endmodule

FILE: sv/fpm_merge.sv
module fpm_merge
    import fpm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [1:0] i_channel,
    input  t_lane_stat i_stat [CHANNELS],
    fpm_stream_if.source o_out
);

    t_fpm_out n_out, r_out;
    logic     r_valid;

    // Select the reported lane and collect finish events
    always_comb begin
        n_out = '0;
        n_out.report_channel = i_channel;
        for (int i = 0; i < CHANNELS; i++) begin
            if (32'(i_channel) == i) begin
                n_out.elapsed_ms = i_stat[i].elapsed;
                n_out.liters     = i_stat[i].liters;
                n_out.running    = i_stat[i].running;
                n_out.done_res   = i_stat[i].done;
                n_out.failed     = i_stat[i].failed;
            end
            if (i < PIN_COUNT) begin
                n_out.done_mask[i[1:0]]  = i_stat[i].ev_done;
                n_out.error_mask[i[1:0]] = i_stat[i].ev_err;
            end
        end
    end

    // Output register: load on transfer in, drop on transfer out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_valid;
    assign o_out.payload = r_out;

endmodule

FILE: sv/flow_pulse_meter_bank_core.sv
// Flow meter timer bank. Each input item (millisecond tick, start, stop or
// seconds tick) yields exactly one result in the output register in the
// next cycle; one item per cycle is sustained while the receiver reads every
// result, and a new item is taken whenever the output register is empty or
// being read out in the same cycle. Every channel has its own lane that
// updates all its counters as the item is taken; a merge stage picks the
// reported channel's status and gathers the per-channel finish masks.
module flow_pulse_meter_bank_core
    import fpm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fpm_stream_if.sink   i_in,
    fpm_stream_if.source o_out
);

    logic               fire;
    logic [LIMIT_W-1:0] min_ms;
    logic [LIMIT_W-1:0] max_ms;
    t_lane_stat         lane_stat [CHANNELS];

    // Accept while the output register is free or emptying
    assign i_in.ready = !o_out.valid || o_out.ready;
    assign fire       = i_in.valid && i_in.ready;

    // Shared seconds-to-milliseconds conversion for start items
    assign min_ms = sec_to_ms(i_in.payload.min_seconds);
    assign max_ms = sec_to_ms(i_in.payload.max_seconds);

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        fpm_lane #(
            .LANE_IDX (g)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_fire       (fire),
            .i_op         (i_in.payload.operation),
            .i_channel    (i_in.payload.channel),
            .i_pin_levels (i_in.payload.pin_levels),
            .i_min_ms     (min_ms),
            .i_max_ms     (max_ms),
            .o_stat       (lane_stat[g])
        );
    end

    fpm_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_channel (i_in.payload.channel),
        .i_stat    (lane_stat),
        .o_out     (o_out)
    );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import fpm_pkg::*;
();

    localparam int NUM_CH       = 4;
    localparam int RAND_ITEMS   = 600;
    localparam int PHASE_LEN    = 75;
    localparam int PRESS_AT     = 300;
    localparam int PRESS_CYCLES = 64;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum logic [1:0] {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } t_phase;

    typedef struct {
        t_fpm_in  stim;
        bit       typed;
        t_fpm_out want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    fpm_stream_if #(.t_payload(t_fpm_in))  meter_in ();
    fpm_stream_if #(.t_payload(t_fpm_out)) meter_out ();

    flow_pulse_meter_bank_core #(.CHANNELS(NUM_CH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (meter_in),
        .o_out   (meter_out)
    );

    // Per-channel meter state of the predictor
    logic [ELAPSED_W-1:0]      chan_elapsed [NUM_CH];
    logic [IDLE_W-1:0]         chan_idle    [NUM_CH];
    logic signed [LITER_W-1:0] chan_liters  [NUM_CH];
    logic [LIMIT_W-1:0]        chan_min_ms  [NUM_CH];
    logic [LIMIT_W-1:0]        chan_max_ms  [NUM_CH];
    logic                      chan_prev_act[NUM_CH];
    logic                      chan_run     [NUM_CH];
    logic                      chan_done    [NUM_CH];
    logic                      chan_fail    [NUM_CH];
    logic                      chan_ticked  [NUM_CH];

    t_fpm_out status_q[$];
    t_dir_row dir_rows[$];

    t_phase phase = PH_FREE;
    int     hold_seq = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     quiet_cycles = 0;
    int     err_count = 0;
    int     checked = 0;
    int     op_count[4] = '{0, 0, 0, 0};
    int     done_events = 0;
    int     error_events = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_fpm_in mk_in(t_op op, logic [1:0] ch, logic [3:0] pins,
                                      logic [SEC_W-1:0] mins, logic [SEC_W-1:0] maxs);
        t_fpm_in it;
        it.operation   = op;
        it.channel     = ch;
        it.pin_levels  = pins;
        it.min_seconds = mins;
        it.max_seconds = maxs;
        return it;
    endfunction

    function automatic t_fpm_out mk_out(logic [1:0] ch, int elapsed, int liters,
                                        logic run, logic done, logic fail,
                                        logic [3:0] dmask, logic [3:0] emask);
        t_fpm_out st;
        st.report_channel = ch;
        st.elapsed_ms     = ELAPSED_W'(elapsed);
        st.liters         = LITER_W'(liters);
        st.running        = run;
        st.done_res       = done;
        st.failed         = fail;
        st.done_mask      = dmask;
        st.error_mask     = emask;
        return st;
    endfunction

    // Percentage of cycles spent idle on one side in the current phase
    function automatic int pause_pct(t_phase ph, bit sender);
        case (ph)
            PH_SEND_IDLE:  return sender ? 88 : 0;
            PH_RECV_STALL: return sender ? 0 : 88;
            PH_BOTH:       return 30;
            default:       return 0;
        endcase
    endfunction

    // Close one channel and flag it in the finish masks
    task automatic end_channel(input int c, input bit with_err,
                               inout logic [3:0] dmask, inout logic [3:0] emask);
        chan_run[c]  = 1'b0;
        chan_done[c] = !with_err;
        chan_fail[c] = with_err;
        if (with_err) emask[c] = 1'b1;
        else          dmask[c] = 1'b1;
    endtask

    // Advance one running channel by a millisecond
    task automatic tick_channel(input int c, input logic [3:0] pins,
                                inout logic [3:0] dmask, inout logic [3:0] emask);
        logic act;
        if (chan_idle[c] != {IDLE_W{1'b1}}) chan_idle[c] = chan_idle[c] + 1'b1;
        if (chan_liters[c] >= 0 && chan_elapsed[c] != {ELAPSED_W{1'b1}})
            chan_elapsed[c] = chan_elapsed[c] + 1'b1;
        if (chan_idle[c] > chan_max_ms[c]) begin
            end_channel(c, 1'b1, dmask, emask);
            return;
        end
        // pins are active low; count a pulse on the inactive-to-active edge
        act = !pins[c];
        if (!chan_prev_act[c] && act) begin
            if (chan_liters[c] < LITER_MAX) chan_liters[c] = chan_liters[c] + 24'sd1;
            chan_idle[c] = '0;
            if (chan_elapsed[c] > chan_min_ms[c]) begin
                end_channel(c, 1'b0, dmask, emask);
                return;
            end
        end
        chan_prev_act[c] = act;
    endtask

    // Apply one transfer to the meter bank and return the status it reports
    task automatic predict_status(input t_fpm_in it, output t_fpm_out st);
        logic [3:0] dmask;
        logic [3:0] emask;
        int c;
        dmask = '0;
        emask = '0;
        c = it.channel;
        case (t_op'(it.operation))
            OP_MS_TICK: begin
                for (int i = 0; i < NUM_CH; i++) begin
                    chan_ticked[i] = 1'b1;
                    if (chan_run[i]) tick_channel(i, it.pin_levels, dmask, emask);
                end
            end
            OP_START: begin
                chan_done[c]     = 1'b0;
                chan_fail[c]     = 1'b0;
                chan_elapsed[c]  = '0;
                chan_idle[c]     = '0;
                chan_liters[c]   = LITER_NONE;
                chan_prev_act[c] = !it.pin_levels[c];
                chan_min_ms[c]   = it.min_seconds * 22'd1000;
                chan_max_ms[c]   = it.max_seconds * 22'd1000;
                chan_ticked[c]   = 1'b0;
                chan_run[c]      = 1'b1;
            end
            OP_STOP: end_channel(c, 1'b0, dmask, emask);
            default: begin
                for (int i = 0; i < NUM_CH; i++) begin
                    if (chan_run[i] && !chan_ticked[i]) end_channel(i, 1'b1, dmask, emask);
                    chan_ticked[i] = 1'b0;
                end
            end
        endcase
        st.report_channel = it.channel;
        st.elapsed_ms     = chan_elapsed[c];
        st.liters         = chan_liters[c];
        st.running        = chan_run[c];
        st.done_res       = chan_done[c];
        st.failed         = chan_fail[c];
        st.done_mask      = dmask;
        st.error_mask     = emask;
    endtask

    // Offer one item, wait for its transfer, then queue its expected status
    task automatic send_item(input t_fpm_in it, input bit typed, input t_fpm_out want,
                             input bit in_random, input int rand_idx);
        t_fpm_out st;
        if (in_random) begin
            case ((rand_idx / PHASE_LEN) % 4)
                0:       phase = PH_FREE;
                1:       phase = PH_SEND_IDLE;
                2:       phase = PH_RECV_STALL;
                default: phase = PH_BOTH;
            endcase
            if (rand_idx == PRESS_AT) hold_seq++;
        end
        @(negedge i_clk);
        while ($urandom_range(99) < pause_pct(phase, 1'b1)) begin
            meter_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        meter_in.valid   <= 1'b1;
        meter_in.payload <= it;
        do @(posedge i_clk); while (!meter_in.ready);
        predict_status(it, st);
        status_q.push_back(typed ? want : st);
        op_count[it.operation]++;
    endtask

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            meter_out.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = PRESS_CYCLES - 1;
            meter_out.ready <= 1'b0;
        end else begin
            meter_out.ready <= ($urandom_range(99) >= pause_pct(phase, 1'b0));
        end
    end

    // Check each status transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_fpm_out want;
        t_fpm_out got;
        if (i_rst_n && meter_out.valid && meter_out.ready) begin
            got = meter_out.payload;
            if (status_q.size() == 0) begin
                $display("%0t: status transfer with nothing expected, actual %p", $time, got);
                err_count++;
            end else begin
                want = status_q.pop_front();
                cmp_field("report_channel", want.report_channel, got.report_channel);
                cmp_field("elapsed_ms", want.elapsed_ms, got.elapsed_ms);
                cmp_field("liters", int'(want.liters), int'(got.liters));
                cmp_field("running", want.running, got.running);
                cmp_field("done_res", want.done_res, got.done_res);
                cmp_field("failed", want.failed, got.failed);
                cmp_field("done_mask", want.done_mask, got.done_mask);
                cmp_field("error_mask", want.error_mask, got.error_mask);
                checked++;
            end
            done_events  += $countones(got.done_mask);
            error_events += $countones(got.error_mask);
        end
        // count cycles with no transfer on either side
        if ((meter_in.valid && meter_in.ready) || (meter_out.valid && meter_out.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    // Stimulus
    initial begin
        t_fpm_out   none;
        logic [3:0] pins;
        logic [1:0] ch;
        logic [SEC_W-1:0] mins;
        logic [SEC_W-1:0] maxs;
        int r;
        int n;
        int rand_idx;

        none = '0;
        i_rst_n = 1'b0;
        meter_in.valid = 1'b0;
        meter_in.payload = '0;
        meter_out.ready = 1'b1;
        for (int i = 0; i < NUM_CH; i++) begin
            chan_elapsed[i]  = '0;
            chan_idle[i]     = '0;
            chan_liters[i]   = '0;
            chan_min_ms[i]   = '0;
            chan_max_ms[i]   = '0;
            chan_prev_act[i] = 1'b0;
            chan_run[i]      = 1'b0;
            chan_done[i]     = 1'b0;
            chan_fail[i]     = 1'b0;
            chan_ticked[i]   = 1'b0;
        end

        // tick after reset, stop on an idle channel, missing tick, zero idle limit
        dir_rows.push_back('{mk_in(OP_MS_TICK, 2'd0, 4'hF, 12'd0, 12'd0), 1'b1,
                             mk_out(2'd0, 0, 0, 0, 0, 0, 4'b0000, 4'b0000)});
        dir_rows.push_back('{mk_in(OP_STOP, 2'd2, 4'hF, 12'd0, 12'd0), 1'b1,
                             mk_out(2'd2, 0, 0, 0, 1, 0, 4'b0100, 4'b0000)});
        dir_rows.push_back('{mk_in(OP_START, 2'd1, 4'hF, 12'd0, 12'd0), 1'b1,
                             mk_out(2'd1, 0, -1, 1, 0, 0, 4'b0000, 4'b0000)});
        dir_rows.push_back('{mk_in(OP_SEC_TICK, 2'd1, 4'hF, 12'd0, 12'd0), 1'b1,
                             mk_out(2'd1, 0, -1, 0, 0, 1, 4'b0000, 4'b0010)});
        dir_rows.push_back('{mk_in(OP_START, 2'd0, 4'hF, 12'd0, 12'd0), 1'b1,
                             mk_out(2'd0, 0, -1, 1, 0, 0, 4'b0000, 4'b0000)});
        dir_rows.push_back('{mk_in(OP_MS_TICK, 2'd0, 4'hF, 12'd0, 12'd0), 1'b1,
                             mk_out(2'd0, 0, -1, 0, 0, 1, 4'b0000, 4'b0001)});
        // widest limits, pin already active at start
        dir_rows.push_back('{mk_in(OP_START, 2'd3, 4'h0, 12'hFFF, 12'hFFF), 1'b1,
                             mk_out(2'd3, 0, -1, 1, 0, 0, 4'b0000, 4'b0000)});
        dir_rows.push_back('{mk_in(OP_MS_TICK, 2'd3, 4'h0, 12'hFFF, 12'h000), 1'b0, none});
        dir_rows.push_back('{mk_in(OP_MS_TICK, 2'd3, 4'hF, 12'h000, 12'hFFF), 1'b0, none});
        dir_rows.push_back('{mk_in(OP_MS_TICK, 2'd3, 4'h0, 12'h0, 12'h0), 1'b0, none});
        dir_rows.push_back('{mk_in(OP_MS_TICK, 2'd3, 4'hF, 12'h0, 12'h0), 1'b0, none});
        dir_rows.push_back('{mk_in(OP_MS_TICK, 2'd3, 4'h0, 12'h0, 12'h0), 1'b0, none});
        dir_rows.push_back('{mk_in(OP_SEC_TICK, 2'd3, 4'h0, 12'h0, 12'h0), 1'b0, none});
        // zero minimum: the second pulse ends the run as done
        dir_rows.push_back('{mk_in(OP_START, 2'd0, 4'hF, 12'd0, 12'd1), 1'b0, none});
        dir_rows.push_back('{mk_in(OP_MS_TICK, 2'd0, 4'hE, 12'd0, 12'd0), 1'b0, none});
        dir_rows.push_back('{mk_in(OP_MS_TICK, 2'd0, 4'hF, 12'd0, 12'd0), 1'b0, none});
        dir_rows.push_back('{mk_in(OP_MS_TICK, 2'd0, 4'hE, 12'd0, 12'd0), 1'b0, none});
        // re-arm a running channel, stop a running and a failed channel
        dir_rows.push_back('{mk_in(OP_START, 2'd3, 4'h5, 12'hAAA, 12'h555), 1'b0, none});
        dir_rows.push_back('{mk_in(OP_STOP, 2'd3, 4'hA, 12'h555, 12'hAAA), 1'b0, none});
        dir_rows.push_back('{mk_in(OP_STOP, 2'd1, 4'h5, 12'h0, 12'h0), 1'b0, none});
        dir_rows.push_back('{mk_in(OP_START, 2'd2, 4'hA, 12'h555, 12'hAAA), 1'b0, none});
        dir_rows.push_back('{mk_in(OP_SEC_TICK, 2'd2, 4'hF, 12'h0, 12'h0), 1'b0, none});

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want, 1'b0, 0);

        // Mostly start-then-tick sequences with random pin activity, some noise
        rand_idx = 0;
        pins = 4'hF;
        while (rand_idx < RAND_ITEMS) begin
            if ($urandom_range(99) < 80) begin
                ch = 2'($urandom_range(3));
                r = $urandom_range(99);
                mins = (r < 75) ? 12'd0 : (r < 85) ? 12'd1 : 12'($urandom);
                r = $urandom_range(99);
                maxs = (r < 15) ? 12'd0 : (r < 85) ? 12'($urandom_range(2, 1)) : 12'($urandom);
                send_item(mk_in(OP_START, ch, pins, mins, maxs), 1'b0, none, 1'b1, rand_idx);
                rand_idx++;
                n = $urandom_range(40, 4);
                for (int k = 0; k < n; k++) begin
                    pins = pins ^ (4'($urandom) & 4'($urandom));
                    r = $urandom_range(99);
                    send_item(mk_in((r < 8) ? OP_SEC_TICK : (r < 11) ? OP_STOP : OP_MS_TICK,
                                    2'($urandom_range(3)), pins, 12'($urandom), 12'($urandom)),
                              1'b0, none, 1'b1, rand_idx);
                    rand_idx++;
                end
            end else begin
                send_item(mk_in(t_op'($urandom_range(3)), 2'($urandom_range(3)), 4'($urandom),
                                12'($urandom), 12'($urandom)), 1'b0, none, 1'b1, rand_idx);
                rand_idx++;
            end
        end

        // Drain
        @(negedge i_clk);
        meter_in.valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("items: %0d ms ticks, %0d starts, %0d stops, %0d seconds ticks",
                 op_count[OP_MS_TICK], op_count[OP_START], op_count[OP_STOP],
                 op_count[OP_SEC_TICK]);
        $display("statuses checked: %0d, channel finishes: %0d done, %0d error",
                 checked, done_events, error_events);
        if (err_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
